// File: hw/rtl/gbm_pkg.sv
`default_nettype none

package gbm_pkg;

   // Remap slots: shoot, bomb, focus, menu, up, down, left, right, skip
   localparam int NUM_SLOTS = 9;
   localparam int SLOT_W    = 6;
   localparam int MAP_W     = NUM_SLOTS * SLOT_W;
   localparam int PAD_W     = 32;
   localparam int PAD_IDX_W = $clog2(PAD_W);
   localparam int BTN_W     = 16;
   localparam int AXIS_W    = 16;
   localparam int THR_W     = 15;
   localparam int TIMER_W   = 5;

   // APB side: 64-bit data, registers on 8-byte strides
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   // Every slot disabled after reset
   localparam logic [MAP_W-1:0] MAP_RESET = 54'h20820820820820;

   // Slot layout
   localparam int SLOT_DISABLE_BIT = 5;

   // Auto-focus hold timer
   localparam logic [TIMER_W-1:0] TIMER_MAX  = 5'd20;
   localparam logic [TIMER_W-1:0] TIMER_STEP = 5'd10;

   // Game button bit positions
   localparam int BIT_SHOOT = 0;
   localparam int BIT_FOCUS = 2;
   localparam int BIT_UP    = 4;
   localparam int BIT_DOWN  = 5;
   localparam int BIT_LEFT  = 6;
   localparam int BIT_RIGHT = 7;
   localparam int BIT_D     = 9;

   // Pad button hard-wired to D
   localparam logic [PAD_IDX_W-1:0] D_PAD_INDEX = 5'd7;

   // Register indexes (byte address / 8)
   typedef enum logic [1:0] {
      REG_BUTTON_MAP = 2'd0,
      REG_AUTO_FOCUS = 2'd1,
      REG_THRESH_X   = 2'd2,
      REG_THRESH_Y   = 2'd3
   } reg_idx_type;

   // Current configuration, from the register block to the mapper
   typedef struct packed {
      logic [MAP_W-1:0] button_map;
      logic             auto_focus_enable;
      logic [THR_W-1:0] axis_threshold_x;
      logic [THR_W-1:0] axis_threshold_y;
   } cfg_type;

endpackage

`default_nettype wire

// File: hw/rtl/gbm_csr.sv
`default_nettype none

module gbm_csr
   import gbm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type reg_idx;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_BUTTON_MAP: cfg_in.button_map        = csr_pwdata[MAP_W-1:0];
            REG_AUTO_FOCUS: cfg_in.auto_focus_enable = csr_pwdata[0];
            REG_THRESH_X:   cfg_in.axis_threshold_x  = csr_pwdata[THR_W-1:0];
            REG_THRESH_Y:   cfg_in.axis_threshold_y  = csr_pwdata[THR_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.button_map        <= MAP_RESET;
         cfg_ff.auto_focus_enable <= 1'b0;
         cfg_ff.axis_threshold_x  <= '0;
         cfg_ff.axis_threshold_y  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      csr_prdata = '0;
      unique case (reg_idx)
         REG_BUTTON_MAP: csr_prdata[MAP_W-1:0] = cfg_ff.button_map;
         REG_AUTO_FOCUS: csr_prdata[0]         = cfg_ff.auto_focus_enable;
         REG_THRESH_X:   csr_prdata[THR_W-1:0] = cfg_ff.axis_threshold_x;
         REG_THRESH_Y:   csr_prdata[THR_W-1:0] = cfg_ff.axis_threshold_y;
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: hw/rtl/gbm_map.sv
`default_nettype none

module gbm_map
   import gbm_pkg::*;
(
   input  wire cfg_type              cfg,
   input  wire logic                 device_ok,
   input  wire logic [BTN_W-1:0]     keyboard_buttons,
   input  wire logic [PAD_W-1:0]     pad_buttons,
   input  wire logic [AXIS_W-1:0]    axis_x,
   input  wire logic [AXIS_W-1:0]    axis_y,
   input  wire logic [TIMER_W-1:0]   timer,
   output logic      [BTN_W-1:0]     game_buttons,
   output logic      [TIMER_W-1:0]   timer_next
);

   logic [NUM_SLOTS-1:0]  slot_hit;
   logic [SLOT_W-1:0]     slot;
   logic [BTN_W-1:0]      btn;
   logic [TIMER_W-1:0]    timer_up;
   logic                  focus_force;
   logic signed [AXIS_W:0] ax;
   logic signed [AXIS_W:0] ay;
   logic signed [AXIS_W:0] tx;
   logic signed [AXIS_W:0] ty;

   // Per-slot lookup of the routed pad button
   always_comb begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
         slot        = cfg.button_map[s*SLOT_W +: SLOT_W];
         slot_hit[s] = !slot[SLOT_DISABLE_BIT] && pad_buttons[slot[PAD_IDX_W-1:0]];
      end
   end

   // Stick compares, widened to 17 bits signed
   assign ax = $signed({axis_x[AXIS_W-1], axis_x});
   assign ay = $signed({axis_y[AXIS_W-1], axis_y});
   assign tx = $signed({2'b00, cfg.axis_threshold_x});
   assign ty = $signed({2'b00, cfg.axis_threshold_y});

   // Auto-focus hold timer
   assign timer_up = (timer < TIMER_MAX) ? timer + 5'd1 : timer;

   always_comb begin
      timer_next  = timer;
      focus_force = 1'b0;
      if (device_ok && cfg.auto_focus_enable) begin
         priority if (slot_hit[BIT_SHOOT]) begin
            timer_next  = timer_up;
            focus_force = (timer_up >= TIMER_STEP);
         end else if (timer > TIMER_STEP) begin
            timer_next  = timer - TIMER_STEP;
            focus_force = 1'b1;
         end else begin
            timer_next  = '0;
         end
      end
   end

   // Merge pad onto keyboard bits
   always_comb begin
      btn = keyboard_buttons;
      if (device_ok) begin
         btn[NUM_SLOTS-1:0] = btn[NUM_SLOTS-1:0] | slot_hit;
         btn[BIT_FOCUS]     = btn[BIT_FOCUS] | focus_force;
         btn[BIT_D]         = btn[BIT_D] | pad_buttons[D_PAD_INDEX];
         btn[BIT_RIGHT]     = btn[BIT_RIGHT] | (ax > tx);
         btn[BIT_LEFT]      = btn[BIT_LEFT] | (ax < -tx);
         btn[BIT_DOWN]      = btn[BIT_DOWN] | (ay > ty);
         btn[BIT_UP]        = btn[BIT_UP] | (ay < -ty);
      end
      game_buttons = btn;
   end

endmodule

`default_nettype wire

// File: hw/rtl/gamepad_button_mapper_core.sv
// Gamepad button mapper core.
// Input stream (req_): one pad poll per transfer. req_tdata carries the
// keyboard bits, pad button mask and the two signed stick axes; req_tuser
// is the device-ok flag. Output stream (rsp_): one 16-bit game button word
// per poll, in poll order.
// Configuration goes through the APB port (button map, auto-focus enable,
// stick thresholds); the user must write it only while the core is idle,
// as the core itself does not enforce this. A poll is registered in the
// input register, then mapped and registered in the result register.
// Throughput: one poll per cycle while the receiver keeps rsp_tready high;
// the hold timer moves only when a poll passes into the result register.
// Reset clears both stages, the hold timer and the registers to their
// defaults (all remap slots disabled, auto-focus off, thresholds zero).
// When the receiver stalls, the result register holds its word and the
// input register still takes one more poll; req_tready drops only when both
// stages are full and rsp_tready is low.
`default_nettype none

module gamepad_button_mapper_core
   import gbm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [15:0] keyboard_buttons, [47:16] pad_buttons, [63:48] axis_x, [79:64] axis_y
   input  wire logic [79:0]           req_tdata,
   // [0] device_ok
   input  wire logic [0:0]            req_tuser,

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [15:0] game_buttons
   output logic      [BTN_W-1:0]      rsp_tdata,

   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type              cfg;

   logic                 s1_valid_ff, s1_valid_in;
   logic [79:0]          s1_data_ff;
   logic                 s1_ok_ff;
   logic                 out_valid_ff, out_valid_in;
   logic [BTN_W-1:0]     out_data_ff;
   logic [TIMER_W-1:0]   timer_ff;

   logic                 req_fire;
   logic                 s1_fire;
   logic [BTN_W-1:0]     map_buttons;
   logic [TIMER_W-1:0]   timer_next;

   gbm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gbm_map u_map (
      .cfg              (cfg),
      .device_ok        (s1_ok_ff),
      .keyboard_buttons (s1_data_ff[15:0]),
      .pad_buttons      (s1_data_ff[47:16]),
      .axis_x           (s1_data_ff[63:48]),
      .axis_y           (s1_data_ff[79:64]),
      .timer            (timer_ff),
      .game_buttons     (map_buttons),
      .timer_next       (timer_next)
   );

   // Handshake between input stage and result stage
   assign s1_fire    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         timer_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_fire) begin
            timer_ff <= timer_next;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_tdata;
         s1_ok_ff   <= req_tuser[0];
      end
      if (s1_fire) begin
         out_data_ff <= map_buttons;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // Backpressure only when both stages hold a poll
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled while a stage was free");

   // Hold timer stays in range
   a_timer_range: assert property (@(posedge clock) disable iff (reset)
      timer_ff <= TIMER_MAX)
      else $error("focus hold timer above its maximum");

   // Timer moves only when a poll is mapped
   a_timer_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(timer_ff))
      else $error("focus hold timer changed without a poll");

   // A mapped poll always lands in the result register
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_tvalid)
      else $error("mapped poll did not produce a result");

endmodule

`default_nettype wire

// File: test/tb_gamepad_button_mapper_core.sv
`default_nettype none

module tb_gamepad_button_mapper_core
   import gbm_pkg::*;
;

   localparam int RUN_LIMIT   = 600000;
   localparam int NUM_PHASES  = 8;
   localparam int PHASE_POLLS = 191;

   // Directed stimulus rows: either a pad poll or a register write
   typedef enum logic {ROW_POLL, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      reg_idx_type        idx;
      logic [63:0]        value;
      logic               ok;
      logic [BTN_W-1:0]   kb;
      logic [PAD_W-1:0]   pad;
      logic [AXIS_W-1:0]  ax;
      logic [AXIS_W-1:0]  ay;
      logic               pinned;
      logic [BTN_W-1:0]   word;
   } stim_row_type;

   typedef struct {
      logic [BTN_W-1:0] word;
      int               seq;
   } pending_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [15:0] keyboard_buttons, [47:16] pad_buttons, [63:48] axis_x, [79:64] axis_y
   logic [79:0]           req_tdata = '0;
   // [0] device_ok
   logic [0:0]            req_tuser = '0;

   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [15:0] game_buttons
   logic [BTN_W-1:0]      rsp_tdata;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Mirror of the block's registers and hold timer
   logic [MAP_W-1:0]      map_cfg       = MAP_RESET;
   logic                  autofocus_cfg = 1'b0;
   logic [THR_W-1:0]      thr_x_cfg     = '0;
   logic [THR_W-1:0]      thr_y_cfg     = '0;
   logic [TIMER_W-1:0]    hold_timer    = '0;

   // Expected game button words, oldest first
   pending_word_type      game_word_q[$];
   stim_row_type          stim_rows[$];

   // Typed-in expectation that rides along with the current poll
   logic                  pin_en   = 1'b0;
   logic [BTN_W-1:0]      pin_word = '0;

   int                    error_count = 0;
   int                    polls_taken = 0;
   int                    cycle_count = 0;

   gamepad_button_mapper_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(string what, int seq, logic [63:0] got, logic [63:0] want);
      $display("mismatch: %s (seq %0d) got %h want %h", what, seq, got, want);
      error_count++;
   endtask

   // Pad button routed through one remap slot; a disabled slot reads released
   function automatic logic slot_pressed(int s, logic [PAD_W-1:0] pad);
      logic [SLOT_W-1:0] slot;
      slot = map_cfg[SLOT_W*s +: SLOT_W];
      if (slot[SLOT_DISABLE_BIT])
         return 1'b0;
      return pad[slot[PAD_IDX_W-1:0]];
   endfunction

   // Game button word for one poll; advances the hold timer mirror
   function automatic logic [BTN_W-1:0] predict_game_word(logic ok, logic [BTN_W-1:0] kb,
                                                           logic [PAD_W-1:0] pad,
                                                           logic signed [AXIS_W-1:0] ax,
                                                           logic signed [AXIS_W-1:0] ay);
      logic [BTN_W-1:0] w;
      int sx;
      int sy;
      int tx;
      int ty;
      w = kb;
      if (!ok)
         return w;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         if (slot_pressed(s, pad))
            w[s] = 1'b1;
      end
      // Auto-focus: count up while shoot is held, fade out after release
      if (autofocus_cfg) begin
         if (slot_pressed(0, pad)) begin
            if (hold_timer < TIMER_MAX)
               hold_timer++;
            if (hold_timer >= TIMER_STEP)
               w[BIT_FOCUS] = 1'b1;
         end else if (hold_timer > TIMER_STEP) begin
            hold_timer -= TIMER_STEP;
            w[BIT_FOCUS] = 1'b1;
         end else begin
            hold_timer = '0;
         end
      end
      if (pad[D_PAD_INDEX])
         w[BIT_D] = 1'b1;
      sx = int'(ax);
      sy = int'(ay);
      tx = int'(thr_x_cfg);
      ty = int'(thr_y_cfg);
      if (sx > tx)
         w[BIT_RIGHT] = 1'b1;
      if (sx < -tx)
         w[BIT_LEFT] = 1'b1;
      if (sy > ty)
         w[BIT_DOWN] = 1'b1;
      if (sy < -ty)
         w[BIT_UP] = 1'b1;
      return w;
   endfunction

   // Result check and prediction, both at the rising edge
   always @(posedge clock) begin : monitor
      logic [BTN_W-1:0] want;
      pending_word_type head;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (game_word_q.size() == 0) begin
               report_mismatch("game_buttons with nothing pending", -1, 64'(rsp_tdata), '0);
            end else begin
               head = game_word_q.pop_front();
               if (rsp_tdata !== head.word)
                  report_mismatch("game_buttons", head.seq, 64'(rsp_tdata), 64'(head.word));
            end
         end
         if (req_tvalid && req_tready) begin
            want = predict_game_word(req_tuser[0], req_tdata[15:0], req_tdata[47:16],
                                     req_tdata[63:48], req_tdata[79:64]);
            if (pin_en)
               want = pin_word;
            game_word_q.push_back('{want, polls_taken});
            polls_taken++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("[gamepad_button_mapper_core] ERROR");
         $finish;
      end
   end

   // Receiver: ready stretches of varied length with short and long stalls
   initial begin : receiver
      int on_len;
      int stall_len;
      int r;
      @(negedge clock);
      forever begin
         on_len = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
         r = $urandom_range(0, 99);
         if (r < 70)
            stall_len = $urandom_range(0, 1);
         else if (r < 95)
            stall_len = $urandom_range(2, 5);
         else
            stall_len = $urandom_range(20, 60);
         rsp_tready <= 1'b1;
         repeat (on_len) @(negedge clock);
         if (stall_len > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall_len) @(negedge clock);
         end
      end
   end

   // One poll transfer; called and returns at a falling edge
   task automatic send_poll(logic ok, logic [BTN_W-1:0] kb, logic [PAD_W-1:0] pad,
                            logic [AXIS_W-1:0] ax, logic [AXIS_W-1:0] ay,
                            logic pinned, logic [BTN_W-1:0] word, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ay, ax, pad, kb};
      req_tuser  <= ok;
      pin_en     <= pinned;
      pin_word   <= word;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Hold the sender until every pending result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (game_word_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Register write, then read back against the mirror
   task automatic csr_access(reg_idx_type idx, logic [63:0] value);
      logic [63:0] stored;
      logic [63:0] got;
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= {idx, 3'b000};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_BUTTON_MAP: begin
            map_cfg = value[MAP_W-1:0];
            stored  = 64'(map_cfg);
         end
         REG_AUTO_FOCUS: begin
            autofocus_cfg = value[0];
            stored        = 64'(autofocus_cfg);
         end
         REG_THRESH_X: begin
            thr_x_cfg = value[THR_W-1:0];
            stored    = 64'(thr_x_cfg);
         end
         default: begin
            thr_y_cfg = value[THR_W-1:0];
            stored    = 64'(thr_y_cfg);
         end
      endcase
      @(negedge clock);
      csr_psel <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      if (got !== stored)
         report_mismatch("register readback", int'(idx), got, stored);
   endtask

   function automatic stim_row_type poll_row(logic ok, logic [BTN_W-1:0] kb,
                                             logic [PAD_W-1:0] pad,
                                             logic [AXIS_W-1:0] ax, logic [AXIS_W-1:0] ay,
                                             logic pinned, logic [BTN_W-1:0] word);
      return '{ROW_POLL, REG_BUTTON_MAP, 64'd0, ok, kb, pad, ax, ay, pinned, word};
   endfunction

   function automatic stim_row_type csr_row(reg_idx_type idx, logic [63:0] value);
      return '{ROW_CSR, idx, value, 1'b0, '0, '0, '0, '0, 1'b0, '0};
   endfunction

   // Stick values around the threshold and at the ends of the range
   function automatic logic [AXIS_W-1:0] pick_axis(logic [THR_W-1:0] thr);
      int t;
      t = int'(thr);
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 16'(t);
         2:       return 16'(t + 1);
         3:       return 16'(-t);
         4:       return 16'(-t - 1);
         5:       return 16'h7FFF;
         6:       return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [THR_W-1:0] pick_threshold();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2:       return 15'd1;
         3:       return 15'($urandom_range(0, 3000));
         default: return 15'($urandom);
      endcase
   endfunction

   function automatic int pick_gap(bit gapless);
      int r;
      r = $urandom_range(0, 99);
      if (gapless || r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // One random phase: fresh settings, then shoot hold/release runs and noise
   task automatic run_phase(int p, int n_polls);
      logic [MAP_W-1:0]  map_val;
      logic [THR_W-1:0]  tx;
      logic [THR_W-1:0]  ty;
      logic              af;
      logic [PAD_W-1:0]  pad;
      logic [BTN_W-1:0]  kb;
      logic              ok;
      int                sent;
      int                run_len;
      bit                shoot_on;
      bit                noise;
      bit                gapless;
      if (p == 0) begin
         map_val = '1;
         tx = '1;
         ty = '1;
      end else if (p == 1) begin
         map_val = '0;
         tx = '0;
         ty = '0;
      end else begin
         for (int s = 0; s < NUM_SLOTS; s++)
            map_val[SLOT_W*s +: SLOT_W] = {($urandom_range(0, 7) == 0), 5'($urandom)};
         tx = pick_threshold();
         ty = pick_threshold();
      end
      af = (p != 1 && p != 4);
      drain();
      csr_access(REG_BUTTON_MAP, 64'(map_val));
      csr_access(REG_AUTO_FOCUS, 64'(af));
      csr_access(REG_THRESH_X, 64'(tx));
      csr_access(REG_THRESH_Y, 64'(ty));
      sent = 0;
      while (sent < n_polls) begin
         noise    = ($urandom_range(0, 3) == 0);
         run_len  = noise ? $urandom_range(1, 10) : $urandom_range(1, 30);
         shoot_on = ($urandom_range(0, 4) < 3);
         gapless  = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < run_len && sent < n_polls; k++) begin
            pad = $urandom;
            kb  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : '0;
            if (noise) begin
               ok = ($urandom_range(0, 1) == 1);
            end else begin
               ok = ($urandom_range(0, 19) != 0);
               // keep the shoot button steady through the run
               if (!map_val[SLOT_DISABLE_BIT])
                  pad[map_val[PAD_IDX_W-1:0]] = shoot_on;
            end
            if ($urandom_range(0, 149) == 0)
               drain();
            send_poll(ok, kb, pad, pick_axis(tx), pick_axis(ty), 1'b0, '0, pick_gap(gapless));
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      // Defaults after reset: all slots off, thresholds zero, auto-focus off
      stim_rows.push_back(poll_row(1'b0, 16'hFFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 1'b1, 16'hFFFF));
      stim_rows.push_back(poll_row(1'b1, 16'h0000, 32'h0000_0000, 16'h0000, 16'h0000, 1'b1, 16'h0000));
      stim_rows.push_back(poll_row(1'b1, 16'h0000, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 1'b1, 16'h0200));
      stim_rows.push_back(poll_row(1'b1, 16'h0000, 32'h0000_0000, 16'h7FFF, 16'h7FFF, 1'b1, 16'h00A0));
      stim_rows.push_back(poll_row(1'b1, 16'h0000, 32'h0000_0000, 16'h8000, 16'h8000, 1'b1, 16'h0050));
      stim_rows.push_back(poll_row(1'b1, 16'hFC00, 32'h0000_0080, 16'h0001, 16'hFFFF, 1'b1, 16'hFE90));
      // Maximum thresholds: only the most negative axis value trips
      stim_rows.push_back(csr_row(REG_THRESH_X, 64'h7FFF));
      stim_rows.push_back(csr_row(REG_THRESH_Y, 64'h7FFF));
      stim_rows.push_back(poll_row(1'b1, 16'h0000, 32'h0000_0000, 16'h7FFF, 16'h7FFF, 1'b1, 16'h0000));
      stim_rows.push_back(poll_row(1'b1, 16'h0000, 32'h0000_0000, 16'h8000, 16'h8000, 1'b1, 16'h0050));
      stim_rows.push_back(poll_row(1'b1, 16'h0000, 32'h0000_0000, 16'h8001, 16'h7FFE, 1'b1, 16'h0000));
      // Slot s reads pad button s, auto-focus on
      stim_rows.push_back(csr_row(REG_BUTTON_MAP, 64'h081C61440C2040));
      stim_rows.push_back(csr_row(REG_AUTO_FOCUS, 64'h1));
      stim_rows.push_back(csr_row(REG_THRESH_X, 64'h0));
      stim_rows.push_back(csr_row(REG_THRESH_Y, 64'h0));
      stim_rows.push_back(poll_row(1'b1, 16'h0000, 32'h0000_01FF, 16'h0000, 16'h0000, 1'b1, 16'h03FF));
      // Hold shoot until focus is forced
      for (int i = 0; i < 9; i++)
         stim_rows.push_back(poll_row(1'b1, 16'h0000, 32'h0000_0001, 16'h0000, 16'h0000, 1'b0, '0));
      // Failed poll in the middle of a hold leaves the timer alone
      stim_rows.push_back(poll_row(1'b0, 16'h0000, 32'h0000_0001, 16'h0000, 16'h0000, 1'b1, 16'h0000));
      stim_rows.push_back(poll_row(1'b1, 16'h0000, 32'h0000_0001, 16'h0000, 16'h0000, 1'b0, '0));
      // Release: focus fades, then the timer clears
      stim_rows.push_back(poll_row(1'b1, 16'h0000, 32'h0000_0000, 16'h0000, 16'h0000, 1'b0, '0));
      stim_rows.push_back(poll_row(1'b1, 16'h0000, 32'h0000_0000, 16'h0000, 16'h0000, 1'b0, '0));
      stim_rows.push_back(poll_row(1'b1, 16'h0000, 32'hFFFF_FFFE, 16'h0000, 16'h0000, 1'b0, '0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR) begin
            drain();
            csr_access(stim_rows[i].idx, stim_rows[i].value);
         end else begin
            send_poll(stim_rows[i].ok, stim_rows[i].kb, stim_rows[i].pad, stim_rows[i].ax,
                      stim_rows[i].ay, stim_rows[i].pinned, stim_rows[i].word, 0);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++)
         run_phase(p, PHASE_POLLS);

      drain();
      repeat (8) @(negedge clock);
      if (error_count == 0 && game_word_q.size() == 0)
         $display("[gamepad_button_mapper_core] OK");
      else
         $display("[gamepad_button_mapper_core] ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/gbm_pkg.sv
hw/rtl/gbm_csr.sv
hw/rtl/gbm_map.sv
hw/rtl/gamepad_button_mapper_core.sv
test/tb_gamepad_button_mapper_core.sv
